/* rtl/ipu_pkg.sv */
// ipu_pkg: shared types, widths and helpers for the integer pixel upscaler.
// Used by every module under rtl/; depends on nothing.
package ipu_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_SCALE   = 8;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W     = 11;
    localparam int SCALE_W     = 4;
    localparam int IDX_W       = $clog2(MAX_SCALE);
    localparam int COORD_W     = 13;
    localparam int PIX_W       = 32;
    localparam int OUT_DATA_W  = 64;
    localparam int ADDR_W      = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_SCALE    = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_BRT_TL   = 3'd3;
    localparam logic [2:0] REG_BRT_TR   = 3'd4;
    localparam logic [2:0] REG_BRT_BL   = 3'd5;
    localparam logic [2:0] REG_BRT_BR   = 3'd6;
    localparam logic [2:0] REG_ROTATION = 3'd7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic               mode;
        logic [SCALE_W-1:0] scale;
        logic [WIDTH_W-1:0] frame_width;
        logic [7:0]         brt_tl;
        logic [7:0]         brt_tr;
        logic [7:0]         brt_bl;
        logic [7:0]         brt_br;
        logic [1:0]         rotation;
    } t_cfg;

    // one source pixel with its block origin; bright in emit order tl, tr, bl, br
    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [SCALE_W-1:0] span;
        logic               lcd;
        logic [3:0][7:0]    bright;
    } t_job;

    // c*l/255 truncated, exact for products of two 8-bit values
    function automatic logic [7:0] dim_chan(input logic [15:0] prod);
        logic [15:0] sum;
        sum = prod + 16'd1 + {8'd0, prod[15:8]};
        return sum[15:8];
    endfunction

endpackage

/* rtl/ipu_regs.sv */
// ipu_regs: APB register file holding the upscaler configuration.
// Depends on ipu_pkg.
module ipu_regs import ipu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= 1'b0;
            r_cfg.scale       <= SCALE_W'(2);
            r_cfg.frame_width <= WIDTH_W'(256);
            r_cfg.brt_tl      <= 8'hFF;
            r_cfg.brt_tr      <= 8'hFF;
            r_cfg.brt_bl      <= 8'hFF;
            r_cfg.brt_br      <= 8'hFF;
            r_cfg.rotation    <= 2'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:     r_cfg.mode        <= pwdata[0];
                REG_SCALE:    r_cfg.scale       <= pwdata[SCALE_W-1:0];
                REG_WIDTH:    r_cfg.frame_width <= pwdata[WIDTH_W-1:0];
                REG_BRT_TL:   r_cfg.brt_tl      <= pwdata[7:0];
                REG_BRT_TR:   r_cfg.brt_tr      <= pwdata[7:0];
                REG_BRT_BL:   r_cfg.brt_bl      <= pwdata[7:0];
                REG_BRT_BR:   r_cfg.brt_br      <= pwdata[7:0];
                REG_ROTATION: r_cfg.rotation    <= pwdata[1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (reg_idx)
            REG_MODE:     prdata = {31'd0, r_cfg.mode};
            REG_SCALE:    prdata = {{(32-SCALE_W){1'b0}}, r_cfg.scale};
            REG_WIDTH:    prdata = {{(32-WIDTH_W){1'b0}}, r_cfg.frame_width};
            REG_BRT_TL:   prdata = {24'd0, r_cfg.brt_tl};
            REG_BRT_TR:   prdata = {24'd0, r_cfg.brt_tr};
            REG_BRT_BL:   prdata = {24'd0, r_cfg.brt_bl};
            REG_BRT_BR:   prdata = {24'd0, r_cfg.brt_br};
            REG_ROTATION: prdata = {30'd0, r_cfg.rotation};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/ipu_front.sv */
// ipu_front: accepts source words, tracks column/row, builds block jobs.
// Depends on ipu_pkg.
module ipu_front import ipu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_frame_start,
    output logic             o_ready,
    input  logic             i_q_full,
    output logic             o_push,
    output t_job             o_job
);

    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [WIDTH_W-1:0] w_eff;
    logic [WIDTH_W-1:0] col_inc;
    logic [SCALE_W-1:0] span;
    logic [3:0][7:0]    ring;
    logic [1:0]         q;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_row = i_frame_start ? '0 : r_row;

    always_comb begin
        if (i_cfg.frame_width == '0)
            w_eff = WIDTH_W'(1);
        else if (i_cfg.frame_width > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = i_cfg.frame_width;

        if (i_cfg.mode)
            span = SCALE_W'(2);
        else if (i_cfg.scale == '0)
            span = SCALE_W'(1);
        else if (i_cfg.scale > SCALE_W'(MAX_SCALE))
            span = SCALE_W'(MAX_SCALE);
        else
            span = i_cfg.scale;

        col_inc = WIDTH_W'(cur_col) + WIDTH_W'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (cur_row == ROW_W'(MAX_HEIGHT - 1)) ? '0 : cur_row + ROW_W'(1);
        end else begin
            n_col = cur_col + COL_W'(1);
            n_row = cur_row;
        end
    end

    // clockwise ring tl, tr, br, bl
    assign ring = {i_cfg.brt_bl, i_cfg.brt_br, i_cfg.brt_tr, i_cfg.brt_tl};
    assign q    = i_cfg.rotation;

    always_comb begin
        o_job.pixel     = i_pixel;
        o_job.x0        = COORD_W'(cur_col) * COORD_W'(span);
        o_job.y0        = COORD_W'(cur_row) * COORD_W'(span);
        o_job.span      = span;
        o_job.lcd       = i_cfg.mode;
        o_job.bright[0] = ring[q];
        o_job.bright[1] = ring[q + 2'd1];
        o_job.bright[2] = ring[q + 2'd3];
        o_job.bright[3] = ring[q + 2'd2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* rtl/ipu_fifo.sv */
// ipu_fifo: short job queue between front and back.
// Depends on ipu_pkg.
module ipu_fifo import ipu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop)
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (i_push && !do_pop)
                r_count <= r_count + (QPTR_W+1)'(1);
            else if (do_pop && !i_push)
                r_count <= r_count - (QPTR_W+1)'(1);
        end
    end

endmodule

/* rtl/ipu_back.sv */
// ipu_back: walks each job's block row-major, dims LCD sub-pixels, drives output word.
// Depends on ipu_pkg.
module ipu_back import ipu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  t_job                  i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data,
    output logic                  o_last
);

    logic [IDX_W-1:0]      r_i, r_j;
    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;
    logic                  r_last;

    logic                  advance;
    logic                  end_i, end_j;
    logic [COORD_W-1:0]    x, y;
    logic [7:0]            level;
    logic [15:0]           prod_r, prod_g, prod_b;
    logic [PIX_W-1:0]      color;

    assign advance = i_job_valid && (!r_valid || i_ready);
    assign end_i   = (SCALE_W'(r_i) + SCALE_W'(1)) == i_job.span;
    assign end_j   = (SCALE_W'(r_j) + SCALE_W'(1)) == i_job.span;
    assign o_pop   = advance && end_i && end_j;

    assign x      = i_job.x0 + COORD_W'(r_i);
    assign y      = i_job.y0 + COORD_W'(r_j);
    assign level  = i_job.bright[{r_j[0], r_i[0]}];
    assign prod_r = i_job.pixel[23:16] * level;
    assign prod_g = i_job.pixel[15:8] * level;
    assign prod_b = i_job.pixel[7:0] * level;
    assign color  = i_job.lcd
                  ? {ALPHA_OPAQUE, dim_chan(prod_r), dim_chan(prod_g), dim_chan(prod_b)}
                  : i_job.pixel;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data <= {{(OUT_DATA_W-PIX_W-2*COORD_W){1'b0}}, color, y, x};
            r_last <= end_i && end_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i     <= '0;
            r_j     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                if (end_i) begin
                    r_i <= '0;
                    r_j <= end_j ? '0 : r_j + IDX_W'(1);
                end else begin
                    r_i <= r_i + IDX_W'(1);
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

/* rtl/integer_pixel_upscaler.sv */
// An accepted source word is first written into the job queue; the back end then registers each output word.
// Throughput: one output word per cycle while a job is queued and i_m_tready is high; a source word gives
// scale*scale output words (scale clamped to 1..8; 4 in LCD grid mode), from the back end's single block walker.
// A 4-deep job queue lets input be taken while earlier blocks are still emitted.
// Reset (synchronous, active low): column/row to 0, queue and output emptied,
// registers to defaults.
module integer_pixel_upscaler import ipu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,   // [31:0] pixel
    input  logic                  i_s_tuser,   // [0] frame_start
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [12:0] out_x, [25:13] out_y, [57:26] color
    output logic                  o_m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg cfg;
    t_job push_job, head_job;
    logic push, q_full, head_valid, pop;

    ipu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ipu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_s_tvalid),
        .i_pixel       (i_s_tdata),
        .i_frame_start (i_s_tuser),
        .o_ready       (o_s_tready),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    ipu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    ipu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_last      (o_m_tlast)
    );

endmodule

/* rtl/ipu_checker.sv */
// ipu_checker: port-level assertions for integer_pixel_upscaler, bound to the top.
// Depends on ipu_pkg.
module ipu_checker import ipu_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast,
    input logic                  pready
);

    logic [COORD_W-1:0] out_y;
    assign out_y = o_m_tdata[2*COORD_W-1:COORD_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_block_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            !o_m_tvalid || out_y == $past(out_y) || out_y == $past(out_y) + COORD_W'(1))
        else $error("row jump inside one block");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OUT_DATA_W-1:PIX_W+2*COORD_W] == '0)
        else $error("tdata pad bits not zero");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind integer_pixel_upscaler ipu_checker u_ipu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .pready     (pready)
);
